### sv/ir_pulse_width_key_decoder_unit_macros.svh
// Assertion helpers for the IR pulse-width decoder.
`ifndef IR_PULSE_WIDTH_KEY_DECODER_UNIT_MACROS_SVH
`define IR_PULSE_WIDTH_KEY_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define IRPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define IRPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ir_pwkd_pkg.sv
package ir_pwkd_pkg;

  localparam int unsigned KEY_BITS_DEF = 8;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned WIDTH_W = 17;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 3;

  localparam logic [1:0] OP_WRAP = 2'd0;
  localparam logic [1:0] OP_RISE = 2'd1;
  localparam logic [1:0] OP_FALL = 2'd2;

  localparam logic [IDX_W-1:0] REG_TIMER_PERIOD = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_MIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_HEADER_MAX   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZERO_MIN     = 3'd3;
  localparam logic [IDX_W-1:0] REG_ZERO_MAX     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ONE_MIN      = 3'd5;
  localparam logic [IDX_W-1:0] REG_ONE_MAX      = 3'd6;

  localparam logic [TIME_W-1:0] RST_TIMER_PERIOD = 16'd20000;
  localparam logic [TIME_W-1:0] RST_HEADER_MIN   = 16'd4000;
  localparam logic [TIME_W-1:0] RST_HEADER_MAX   = 16'd5000;
  localparam logic [TIME_W-1:0] RST_ZERO_MIN     = 16'd460;
  localparam logic [TIME_W-1:0] RST_ZERO_MAX     = 16'd660;
  localparam logic [TIME_W-1:0] RST_ONE_MIN      = 16'd1580;
  localparam logic [TIME_W-1:0] RST_ONE_MAX      = 16'd1780;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [TIME_W-1:0] timer_period;
    logic [TIME_W-1:0] header_min;
    logic [TIME_W-1:0] header_max;
    logic [TIME_W-1:0] zero_min;
    logic [TIME_W-1:0] zero_max;
    logic [TIME_W-1:0] one_min;
    logic [TIME_W-1:0] one_max;
  } cfg_t;

  typedef struct packed {
    logic               neg;
    logic [WIDTH_W-1:0] width;
    logic               hdr;
    logic               zero;
    logic               one;
  } meas_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] pulse_width;
    logic               width_invalid;
    logic               key_valid;
    logic [BYTE_W-1:0]  key_value;
    logic [COUNT_W-1:0] bits_seen;
  } result_t;

endpackage

### sv/ir_pwkd_cfg.sv
module ir_pwkd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ir_pwkd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ir_pwkd_pkg::TIME_W-1:0] cfg_data,
  output ir_pwkd_pkg::cfg_t           cfg
);
  import ir_pwkd_pkg::*;

  assign cfg_ready = 1'b1;

  // indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_period <= RST_TIMER_PERIOD;
      cfg.header_min   <= RST_HEADER_MIN;
      cfg.header_max   <= RST_HEADER_MAX;
      cfg.zero_min     <= RST_ZERO_MIN;
      cfg.zero_max     <= RST_ZERO_MAX;
      cfg.one_min      <= RST_ONE_MIN;
      cfg.one_max      <= RST_ONE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMER_PERIOD: cfg.timer_period <= cfg_data;
        REG_HEADER_MIN:   cfg.header_min   <= cfg_data;
        REG_HEADER_MAX:   cfg.header_max   <= cfg_data;
        REG_ZERO_MIN:     cfg.zero_min     <= cfg_data;
        REG_ZERO_MAX:     cfg.zero_max     <= cfg_data;
        REG_ONE_MIN:      cfg.one_min      <= cfg_data;
        REG_ONE_MAX:      cfg.one_max      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/ir_pwkd_meas.sv
module ir_pwkd_meas (
  input  logic [ir_pwkd_pkg::TIME_W-1:0] capture_time,
  input  logic [ir_pwkd_pkg::TIME_W-1:0] rise_stamp,
  input  logic                           wrap_seen,
  input  ir_pwkd_pkg::cfg_t              cfg,
  output ir_pwkd_pkg::meas_t             meas
);
  import ir_pwkd_pkg::*;

  // one sign bit above the 17-bit width range
  logic [WIDTH_W:0]   diff;
  logic [WIDTH_W:0]   add;
  logic [WIDTH_W-1:0] w;

  assign add  = wrap_seen ? {2'b00, cfg.timer_period} : '0;
  assign diff = {2'b00, capture_time} - {2'b00, rise_stamp} + add;
  assign w    = diff[WIDTH_W-1:0];

  always_comb begin
    meas.neg   = diff[WIDTH_W];
    meas.width = w;
    meas.hdr   = !diff[WIDTH_W] && (w > {1'b0, cfg.header_min}) &&
                 (w < {1'b0, cfg.header_max});
    meas.zero  = !diff[WIDTH_W] && (w > {1'b0, cfg.zero_min}) &&
                 (w < {1'b0, cfg.zero_max});
    meas.one   = !diff[WIDTH_W] && (w > {1'b0, cfg.one_min}) &&
                 (w < {1'b0, cfg.one_max});
  end

endmodule

### sv/ir_pwkd_core.sv
`include "ir_pulse_width_key_decoder_unit_macros.svh"

module ir_pwkd_core #(
  parameter int unsigned KEY_BITS = ir_pwkd_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [1:0]                     op,
  input  logic [ir_pwkd_pkg::TIME_W-1:0] cap,
  input  ir_pwkd_pkg::cfg_t              cfg,
  output ir_pwkd_pkg::result_t           res
);
  import ir_pwkd_pkg::*;

  // header count that marks a full key: header plus KEY_BITS data bits
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(KEY_BITS + 1);

  logic [TIME_W-1:0]  rise_stamp, rise_stamp_next;
  logic               wrap_seen, wrap_seen_next;
  logic [COUNT_W-1:0] frame_count, frame_count_next;
  logic [BYTE_W-1:0]  shift_byte, shift_byte_next;
  logic [BYTE_W-1:0]  latched_key, latched_key_next;
  meas_t              meas;

  ir_pwkd_meas u_meas (
    .capture_time (cap),
    .rise_stamp   (rise_stamp),
    .wrap_seen    (wrap_seen),
    .cfg          (cfg),
    .meas         (meas)
  );

  always_comb begin
    rise_stamp_next  = rise_stamp;
    wrap_seen_next   = wrap_seen;
    frame_count_next = frame_count;
    shift_byte_next  = shift_byte;
    latched_key_next = latched_key;
    res.pulse_width   = '0;
    res.width_invalid = 1'b0;
    res.key_valid     = 1'b0;
    unique case (op)
      OP_WRAP: wrap_seen_next = 1'b1;
      OP_RISE: begin
        rise_stamp_next = cap;
        wrap_seen_next  = 1'b0;
      end
      OP_FALL: begin
        wrap_seen_next = 1'b0;
        if (meas.neg) begin
          res.width_invalid = 1'b1;
        end else begin
          res.pulse_width = meas.width;
          if (meas.hdr) begin
            if (frame_count == FULL_COUNT) begin
              latched_key_next = shift_byte;
              res.key_valid    = 1'b1;
            end
            frame_count_next = COUNT_W'(1);
            shift_byte_next  = '0;
          end else if (frame_count != '0 && (meas.zero || meas.one)) begin
            // zero window wins over one window
            if (frame_count != COUNT_MAX) begin
              frame_count_next = frame_count + COUNT_W'(1);
            end
            shift_byte_next = {shift_byte[BYTE_W-2:0], !meas.zero};
          end
        end
      end
      default: ;
    endcase
    res.key_value = latched_key_next;
    res.bits_seen = frame_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_stamp  <= '0;
      wrap_seen   <= 1'b0;
      frame_count <= '0;
      shift_byte  <= '0;
      latched_key <= '0;
    end else if (fire) begin
      rise_stamp  <= rise_stamp_next;
      wrap_seen   <= wrap_seen_next;
      frame_count <= frame_count_next;
      shift_byte  <= shift_byte_next;
      latched_key <= latched_key_next;
    end
  end

  `IRPW_ASSERT_NOW(a_key_opens_frame, clk, rst, fire && res.key_valid,
    res.bits_seen == COUNT_W'(1), "key latched without frame restart")
  `IRPW_ASSERT_NOW(a_neg_width_quiet, clk, rst, fire && res.width_invalid,
    res.pulse_width == '0 && !res.key_valid, "negative width leaked a result")
  `IRPW_ASSERT_NEXT(a_count_on_fall, clk, rst, !(fire && op == OP_FALL),
    frame_count == $past(frame_count), "bit counter moved without a falling edge")
  `IRPW_ASSERT_NEXT(a_key_hold, clk, rst, !(fire && res.key_valid),
    latched_key == $past(latched_key), "key changed without key_valid")

endmodule

### sv/ir_pulse_width_key_decoder_unit.sv
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_ready   | operation, capture_time
// out     | output    | out_valid / out_ready | pulse_width, width_invalid, key_valid,
//         |           |                       | key_value, bits_seen
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each word passes the input register, then one pass of subtract/compare/shift
// into the output register. One word per cycle sustained while out_ready is high.
// Reset (rst, synchronous) restores register defaults and clears decoder state.
// A stalled output holds the result; the input register still takes a word while
// the result waits, then in_ready drops until out_ready frees the output.
// cfg_ready is always high.
module ir_pulse_width_key_decoder_unit #(
  parameter int unsigned KEY_BITS = ir_pwkd_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      operation,
  input  logic [ir_pwkd_pkg::TIME_W-1:0]  capture_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ir_pwkd_pkg::WIDTH_W-1:0] pulse_width,
  output logic                            width_invalid,
  output logic                            key_valid,
  output logic [ir_pwkd_pkg::BYTE_W-1:0]  key_value,
  output logic [ir_pwkd_pkg::COUNT_W-1:0] bits_seen,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ir_pwkd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ir_pwkd_pkg::TIME_W-1:0]  cfg_data
);
  import ir_pwkd_pkg::*;

  cfg_t              cfg;
  result_t           res;
  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [TIME_W-1:0] s1_cap;
  logic              advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  ir_pwkd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ir_pwkd_core #(
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .op   (s1_op),
    .cap  (s1_cap),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op  <= operation;
      s1_cap <= capture_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pulse_width   <= res.pulse_width;
      width_invalid <= res.width_invalid;
      key_valid     <= res.key_valid;
      key_value     <= res.key_value;
      bits_seen     <= res.bits_seen;
    end
  end

endmodule

### tb/tb_ir_pulse_width_key_decoder_unit.sv
module tb_ir_pulse_width_key_decoder_unit;
  import ir_pwkd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RX_HOLD_LEN = 60;
  localparam int IDLE_PCT = 31;

  localparam cfg_t RESET_CFG = '{
    timer_period: RST_TIMER_PERIOD, header_min: RST_HEADER_MIN,
    header_max: RST_HEADER_MAX, zero_min: RST_ZERO_MIN, zero_max: RST_ZERO_MAX,
    one_min: RST_ONE_MIN, one_max: RST_ONE_MAX
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = OP_WRAP;
  logic [TIME_W-1:0]  capture_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WIDTH_W-1:0] pulse_width;
  logic               width_invalid;
  logic               key_valid;
  logic [BYTE_W-1:0]  key_value;
  logic [COUNT_W-1:0] bits_seen;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = REG_TIMER_PERIOD;
  logic [TIME_W-1:0]  cfg_data = '0;

  ir_pulse_width_key_decoder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .pulse_width(pulse_width), .width_invalid(width_invalid), .key_valid(key_valid),
    .key_value(key_value), .bits_seen(bits_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // decoder shadow state
  cfg_t               cur_cfg = RESET_CFG;
  logic [TIME_W-1:0]  rise_time_q = '0;
  logic               wrap_flag_q = 1'b0;
  logic [COUNT_W-1:0] frame_bits_q = '0;
  logic [BYTE_W-1:0]  byte_shift_q = '0;
  logic [BYTE_W-1:0]  key_byte_q = '0;

  result_t decode_queue[$];
  int      mismatch_count = 0;
  int      words_sent = 0;
  int      cycle_count = 0;
  int      tx_idle_pct = IDLE_PCT;
  int      rx_idle_pct = IDLE_PCT;
  int      rx_hold_req = 0;
  int      rx_hold_ack = 0;
  int      rx_hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus requested long hold-offs
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack = rx_hold_req;
      rx_hold_left = RX_HOLD_LEN;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic bit in_band(input int w, input logic [TIME_W-1:0] lo,
                                 input logic [TIME_W-1:0] hi);
    return w > int'(lo) && w < int'(hi);
  endfunction

  task automatic decode_edge_event(input logic [1:0] op, input logic [TIME_W-1:0] cap,
                                   output result_t r);
    int w;
    r = '0;
    case (op)
      OP_WRAP: wrap_flag_q = 1'b1;
      OP_RISE: begin
        rise_time_q = cap;
        wrap_flag_q = 1'b0;
      end
      OP_FALL: begin
        w = int'(cap) - int'(rise_time_q);
        if (wrap_flag_q) w += int'(cur_cfg.timer_period);
        wrap_flag_q = 1'b0;
        if (w < 0) begin
          r.width_invalid = 1'b1;
        end else begin
          r.pulse_width = w[WIDTH_W-1:0];
          if (in_band(w, cur_cfg.header_min, cur_cfg.header_max)) begin
            if (frame_bits_q == KEY_BITS_DEF + 1) begin
              key_byte_q = byte_shift_q;
              r.key_valid = 1'b1;
            end
            frame_bits_q = COUNT_W'(1);
            byte_shift_q = '0;
          end else if (frame_bits_q != 0) begin
            // zero window checked before one window
            if (in_band(w, cur_cfg.zero_min, cur_cfg.zero_max)) begin
              if (frame_bits_q < COUNT_MAX) frame_bits_q++;
              byte_shift_q = {byte_shift_q[BYTE_W-2:0], 1'b0};
            end else if (in_band(w, cur_cfg.one_min, cur_cfg.one_max)) begin
              if (frame_bits_q < COUNT_MAX) frame_bits_q++;
              byte_shift_q = {byte_shift_q[BYTE_W-2:0], 1'b1};
            end
          end
        end
      end
      default: ;
    endcase
    r.key_value = key_byte_q;
    r.bits_seen = frame_bits_q;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (decode_queue.size() == 0) begin
        report_mismatch("unexpected word, pulse_width", pulse_width, 0);
      end else begin
        want = decode_queue.pop_front();
        if (pulse_width !== want.pulse_width)
          report_mismatch("pulse_width", pulse_width, want.pulse_width);
        if (width_invalid !== want.width_invalid)
          report_mismatch("width_invalid", width_invalid, want.width_invalid);
        if (key_valid !== want.key_valid)
          report_mismatch("key_valid", key_valid, want.key_valid);
        if (key_value !== want.key_value)
          report_mismatch("key_value", key_value, want.key_value);
        if (bits_seen !== want.bits_seen)
          report_mismatch("bits_seen", bits_seen, want.bits_seen);
      end
    end
  end

  // valid stays high into the next call unless an idle gap is taken;
  // each idle cycle is drawn on its own so gaps cover about tx_idle_pct of cycles
  task automatic send_word(input logic [1:0] op, input logic [TIME_W-1:0] cap);
    result_t r;
    in_valid <= 1'b1;
    operation <= op;
    capture_time <= cap;
    do @(posedge clk); while (!in_ready);
    decode_edge_event(op, cap, r);
    decode_queue.push_back(r);
    words_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (decode_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input cfg_t c);
    settle();
    write_reg(REG_TIMER_PERIOD, c.timer_period);
    write_reg(REG_HEADER_MIN, c.header_min);
    write_reg(REG_HEADER_MAX, c.header_max);
    write_reg(REG_ZERO_MIN, c.zero_min);
    write_reg(REG_ZERO_MAX, c.zero_max);
    write_reg(REG_ONE_MIN, c.one_min);
    write_reg(REG_ONE_MAX, c.one_max);
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // rise/fall pair of the given width, sometimes spanning a timer wrap
  task automatic send_pulse(input int width);
    int period, lo_f, hi_f, fall_t, rise_t;
    period = cur_cfg.timer_period;
    lo_f = (width > period) ? width - period : 0;
    hi_f = 65535 + width - period;
    if (hi_f > 65535) hi_f = 65535;
    if (lo_f <= hi_f && (width > 65535 || $urandom_range(3) == 0)) begin
      fall_t = $urandom_range(hi_f, lo_f);
      rise_t = fall_t + period - width;
      send_word(OP_RISE, rise_t[TIME_W-1:0]);
      send_word(OP_WRAP, 16'($urandom_range(65535)));
      send_word(OP_FALL, fall_t[TIME_W-1:0]);
    end else begin
      if (width > 65535) width = 65535;
      rise_t = $urandom_range(65535 - width, 0);
      fall_t = rise_t + width;
      send_word(OP_RISE, rise_t[TIME_W-1:0]);
      send_word(OP_FALL, fall_t[TIME_W-1:0]);
    end
  endtask

  // mostly inside the open window, now and then exactly on a bound; anywhere if no interior
  function automatic int pick_width(input int lo, input int hi);
    int r;
    r = $urandom_range(15);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (hi - lo >= 2) return $urandom_range(hi - 1, lo + 1);
    return $urandom_range(65535);
  endfunction

  task automatic send_frames(input int n_words);
    int stop_at, nbits;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(19) == 0)
        send_word(2'($urandom_range(3)), 16'($urandom_range(65535)));
      send_pulse(pick_width(cur_cfg.header_min, cur_cfg.header_max));
      nbits = ($urandom_range(9) < 7) ? KEY_BITS_DEF : $urandom_range(15);
      repeat (nbits) begin
        if ($urandom_range(1))
          send_pulse(pick_width(cur_cfg.one_min, cur_cfg.one_max));
        else
          send_pulse(pick_width(cur_cfg.zero_min, cur_cfg.zero_max));
      end
    end
  endtask

  task automatic send_events(input int n_words);
    repeat (n_words) send_word(2'($urandom_range(3)), 16'($urandom_range(65535)));
  endtask

  task automatic test_directed_cases();
    logic [BYTE_W-1:0] pattern;
    pattern = 8'hA5;
    send_word(OP_UNUSED, 16'hFFFF);
    send_word(OP_RISE, 16'h0000);
    send_word(OP_FALL, 16'hFFFF);
    send_word(OP_RISE, 16'hFFFF);
    send_word(OP_FALL, 16'h0000);   // negative width
    send_word(OP_RISE, 16'hFFFF);
    send_word(OP_WRAP, 16'h0000);
    send_word(OP_FALL, 16'hFFFF);   // period added once
    // header across a wrap: 44500 - 60000 + 20000 = 4500
    send_word(OP_RISE, 16'd60000);
    send_word(OP_WRAP, 16'hFFFF);
    send_word(OP_FALL, 16'd44500);
    for (int i = BYTE_W - 1; i >= 0; i--)
      send_pulse(pattern[i] ? 1680 : 560);
    send_pulse(4500);               // latches the key
    settle();
  endtask

  task automatic test_reset_settings_frames();
    send_frames(330);
    settle();
  endtask

  task automatic test_window_sweep();
    cfg_t sweep[4];
    sweep[0] = '{16'd1, 16'd99, 16'd101, 16'd9, 16'd11, 16'd19, 16'd21};
    // zero window inside the header window, one window open from 0 to 16'hFFFF
    sweep[1] = '{16'hFFFF, 16'd1000, 16'd2000, 16'd1500, 16'd1600, 16'd0, 16'hFFFF};
    sweep[2] = '{16'd30000, 16'd40000, 16'hFFFF, 16'd0, 16'd300, 16'd65000, 16'hFFFF};
    sweep[3] = '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    foreach (sweep[i]) begin
      load_settings(sweep[i]);
      send_frames(80);
      send_events(15);
    end
    load_settings(RESET_CFG);
  endtask

  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_hold_req++;
    send_frames(40);
    settle();
    tx_idle_pct = IDLE_PCT;
  endtask

  task automatic test_no_gap_stretch();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_frames(120);
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_events();
    send_events(120);
    send_frames(60);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_reset_settings_frames();
    test_window_sweep();
    test_output_stall();
    test_no_gap_stretch();
    test_random_events();
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
